### design/ckvt_pkg.sv
// ckvt_pkg: command and status codes, transaction structs and the search token
// shared by the key/value table cells, the core and its checker.
// no dependencies.
`timescale 1ns / 1ps

package ckvt_pkg;

  localparam int unsigned KeyWidth   = 32;
  localparam int unsigned ValueWidth = 32;
  localparam int unsigned CountWidth = 5;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_FIND   = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;
  localparam logic [1:0] CMD_NOP    = 2'd3;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_MISSING = 2'd1;
  localparam logic [1:0] STATUS_FULL    = 2'd2;

  typedef struct packed {
    logic [1:0]            cmd;
    logic [KeyWidth-1:0]   key;
    logic [ValueWidth-1:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0]            status;
    logic [ValueWidth-1:0] found_value;
    logic [CountWidth-1:0] entry_count;
  } rsp_t;

  // travels down the cell chain, one cell per cycle
  typedef struct packed {
    logic [1:0]            cmd;
    logic [KeyWidth-1:0]   key;
    logic [ValueWidth-1:0] value;
    logic                  hit;
    logic [ValueWidth-1:0] found;
  } tok_t;

endpackage

### design/ckvt_cell.sv
// ckvt_cell: one table slot holding a key/value pair plus one stage of the
// search token pipeline. depends on ckvt_pkg.
`timescale 1ns / 1ps

module ckvt_cell #(
  parameter int unsigned IDX   = 0,
  parameter int unsigned CNT_W = 5
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic [CNT_W-1:0]                   count_i,
  input  logic                               vld_i,
  input  ckvt_pkg::tok_t                     tok_i,
  output logic                               vld_o,
  output ckvt_pkg::tok_t                     tok_o,
  input  logic [ckvt_pkg::KeyWidth-1:0]      nxt_key_i,
  input  logic [ckvt_pkg::ValueWidth-1:0]    nxt_val_i,
  output logic [ckvt_pkg::KeyWidth-1:0]      key_o,
  output logic [ckvt_pkg::ValueWidth-1:0]    val_o
);

  localparam logic [CNT_W-1:0] IdxC = CNT_W'(IDX);

  logic [ckvt_pkg::KeyWidth-1:0]   key_q, key_d;
  logic [ckvt_pkg::ValueWidth-1:0] val_q, val_d;
  logic                            vld_q;
  ckvt_pkg::tok_t                  tok_q, tok_d;
  logic                            match, shift, write;

  assign match = vld_i && !tok_i.hit && (IdxC < count_i) && (tok_i.key == key_q) &&
                 (tok_i.cmd == ckvt_pkg::CMD_FIND || tok_i.cmd == ckvt_pkg::CMD_REMOVE);
  // from the removed slot onward every cell pulls its upper neighbor down
  assign shift = vld_i && (tok_i.cmd == ckvt_pkg::CMD_REMOVE) && (tok_i.hit || match);
  assign write = vld_i && (tok_i.cmd == ckvt_pkg::CMD_INSERT) && (IdxC == count_i);

  always_comb begin
    key_d = key_q;
    val_d = val_q;
    if (write) begin
      key_d = tok_i.key;
      val_d = tok_i.value;
    end else if (shift) begin
      key_d = nxt_key_i;
      val_d = nxt_val_i;
    end
  end

  always_comb begin
    tok_d = tok_i;
    if (match) begin
      tok_d.hit = 1'b1;
      if (tok_i.cmd == ckvt_pkg::CMD_FIND) begin
        tok_d.found = val_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    val_q <= val_d;
    tok_q <= tok_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  assign vld_o = vld_q;
  assign tok_o = tok_q;
  assign key_o = key_q;
  assign val_o = val_q;

endmodule

### design/compacting_key_value_table_core.sv
// compacting_key_value_table_core: insertion-ordered key/value table built as a
// chain of ckvt_cell slots. depends on ckvt_pkg and ckvt_cell.
//
//   channel   strobe / hold     payload   direction
//   request   start / busy      req_i     in
//   response  done_o            rsp_o     out
//
// a transaction enters a token register, then walks the cell chain one slot per
// cycle; the last cell feeds the response register, which raises done_o, and
// start is taken again in the done_o cycle.
// busy is high from accept until the response shows; rsp_o is valid only with
// done_o, for exactly one cycle. reset clears the fill count and all valid flags;
// slot contents stay undefined until written.
`timescale 1ns / 1ps

module compacting_key_value_table_core #(
  parameter int unsigned DEPTH = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  ckvt_pkg::req_t req_i,
  output logic           done_o,
  output ckvt_pkg::rsp_t rsp_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [CntW-1:0] DepthC = CntW'(DEPTH);

  logic [CntW-1:0]                 cnt_q, cnt_d;
  logic                            busy_q;
  logic                            done_q;
  ckvt_pkg::rsp_t                  rsp_q, rsp_d;
  logic                            accept;
  logic                            vld0_q;
  ckvt_pkg::tok_t                  tok0_q;

  logic                            vld  [DEPTH+1];
  ckvt_pkg::tok_t                  tok  [DEPTH+1];
  logic [ckvt_pkg::KeyWidth-1:0]   keys [DEPTH];
  logic [ckvt_pkg::ValueWidth-1:0] vals [DEPTH];
  logic [CntW+ckvt_pkg::CountWidth-1:0] cnt_ext;

  assign accept = start && !busy_q;

  // entry token register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld0_q <= 1'b0;
    end else begin
      vld0_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      tok0_q.cmd   <= req_i.cmd;
      tok0_q.key   <= req_i.key;
      tok0_q.value <= req_i.value;
      tok0_q.hit   <= 1'b0;
      tok0_q.found <= '0;
    end
  end

  assign vld[0] = vld0_q;
  assign tok[0] = tok0_q;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [ckvt_pkg::KeyWidth-1:0]   nk;
    logic [ckvt_pkg::ValueWidth-1:0] nv;
    if (i + 1 < DEPTH) begin : g_mid
      assign nk = keys[i+1];
      assign nv = vals[i+1];
    end else begin : g_last
      assign nk = keys[i];
      assign nv = vals[i];
    end
    ckvt_cell #(.IDX(i), .CNT_W(CntW)) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .count_i   (cnt_q),
      .vld_i     (vld[i]),
      .tok_i     (tok[i]),
      .vld_o     (vld[i+1]),
      .tok_o     (tok[i+1]),
      .nxt_key_i (nk),
      .nxt_val_i (nv),
      .key_o     (keys[i]),
      .val_o     (vals[i])
    );
  end

  always_comb begin
    cnt_d             = cnt_q;
    rsp_d.status      = ckvt_pkg::STATUS_OK;
    rsp_d.found_value = '0;
    case (tok[DEPTH].cmd)
      ckvt_pkg::CMD_INSERT: begin
        if (cnt_q >= DepthC) begin
          rsp_d.status = ckvt_pkg::STATUS_FULL;
        end else begin
          cnt_d = cnt_q + CntW'(1);
        end
      end
      ckvt_pkg::CMD_FIND: begin
        if (tok[DEPTH].hit) begin
          rsp_d.found_value = tok[DEPTH].found;
        end else begin
          rsp_d.status = ckvt_pkg::STATUS_MISSING;
        end
      end
      ckvt_pkg::CMD_REMOVE: begin
        if (tok[DEPTH].hit) begin
          cnt_d = cnt_q - CntW'(1);
        end else begin
          rsp_d.status = ckvt_pkg::STATUS_MISSING;
        end
      end
      default: begin
      end
    endcase
    cnt_ext           = {{ckvt_pkg::CountWidth{1'b0}}, cnt_d};
    rsp_d.entry_count = cnt_ext[ckvt_pkg::CountWidth-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= vld[DEPTH];
      if (vld[DEPTH]) begin
        cnt_q  <= cnt_d;
        busy_q <= 1'b0;
      end else if (accept) begin
        busy_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld[DEPTH]) begin
      rsp_q <= rsp_d;
    end
  end

  assign busy   = busy_q;
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

### design/ckvt_checker.sv
// ckvt_checker: port-level checks on the key/value table core, and the bind
// that attaches it. depends on ckvt_pkg and compacting_key_value_table_core.
`timescale 1ns / 1ps

module ckvt_checker #(
  parameter int unsigned DEPTH = 16
) (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start,
  input logic           busy,
  input logic           done_o,
  input ckvt_pkg::rsp_t rsp_o
);

  localparam logic [ckvt_pkg::CountWidth-1:0] DepthC = ckvt_pkg::CountWidth'(DEPTH);

  // an accepted transaction holds the core busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted transaction did not raise busy");

  // the response cycle frees the core
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("busy during response cycle");

  // one response per transaction, never two in a row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("response strobe held longer than one cycle");

  // full is only reported at capacity, and a full table returns no value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && rsp_o.status == ckvt_pkg::STATUS_FULL |->
      rsp_o.entry_count == DepthC && rsp_o.found_value == '0)
    else $error("full status with wrong count or nonzero value");

  // a miss leaves no value behind
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && rsp_o.status == ckvt_pkg::STATUS_MISSING |-> rsp_o.found_value == '0)
    else $error("missing key reported with a value");

endmodule

bind compacting_key_value_table_core ckvt_checker #(.DEPTH(DEPTH)) u_ckvt_checker (.*);
